// File: sv/ssst_pkg.sv
`default_nettype none

package ssst_pkg;

   localparam int MAX_SLOTS_DEF = 32;

   localparam int SID_W    = 12;
   localparam int DT_W     = 47;
   localparam int MICROS_W = 20;
   localparam int CHG_W    = 24;
   localparam int MC_W     = MICROS_W + CHG_W;
   localparam int MOD_W    = 24;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = 5;
   localparam int ECNT_W   = 6;

   localparam logic [STATUS_W-1:0] ST_OLDER   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EQUAL   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NEWER   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NEWID   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

   localparam logic FUNC_MERGE   = 1'b0;
   localparam logic FUNC_COMPARE = 1'b1;

   localparam logic [1:0] MODE_SEARCH = 2'd0;
   localparam logic [1:0] MODE_CARRY  = 2'd1;
   localparam logic [1:0] MODE_DONE   = 2'd2;

   localparam logic [IDX_W-1:0] IDX_CAP = 5'd31;

   typedef struct packed {
      logic [SID_W-1:0] sid;
      logic [DT_W-1:0]  dt;
      logic [MC_W-1:0]  mc;
      logic [MOD_W-1:0] mod;
   } entry_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic                func;
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    idx;
      logic                inserted;
      entry_type           ent;
   } token_type;

   typedef struct packed {
      logic advance;
      logic full;
   } chain_ctl_type;

endpackage

`default_nettype wire

// File: sv/ssst_cell.sv
`default_nettype none

module ssst_cell
   import ssst_pkg::*;
#(
   parameter int CNT_W = 6,
   parameter int POS   = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire chain_ctl_type    ctl,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic             tok_vld_i,
   input  wire token_type        tok_i,
   output logic                  tok_vld_o,
   output token_type             tok_o
);

   localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(POS);
   localparam logic [IDX_W-1:0] SLOT_IDX = (POS > 31) ? IDX_CAP : IDX_W'(POS);

   entry_type ent_ff, ent_in;
   token_type tok_ff, tok_in;
   logic      tok_vld_ff;
   logic      occupied;
   logic      sid_eq;
   logic      sid_lt;
   logic      newer;
   logic      same;

   assign occupied = count > POS_CNT;
   assign sid_eq   = tok_i.ent.sid == ent_ff.sid;
   assign sid_lt   = tok_i.ent.sid < ent_ff.sid;
   assign newer    = {tok_i.ent.dt, tok_i.ent.mc, tok_i.ent.mod} >
                     {ent_ff.dt, ent_ff.mc, ent_ff.mod};
   assign same     = {tok_i.ent.dt, tok_i.ent.mc, tok_i.ent.mod} ==
                     {ent_ff.dt, ent_ff.mc, ent_ff.mod};

   always_comb begin
      tok_in = tok_i;
      ent_in = ent_ff;
      if (tok_vld_i) begin
         case (tok_i.mode)
            MODE_SEARCH: begin
               if (!occupied) begin
                  tok_in.mode   = MODE_DONE;
                  tok_in.status = ST_NEWID;
                  tok_in.idx    = SLOT_IDX;
                  if (tok_i.func == FUNC_MERGE) begin
                     ent_in          = tok_i.ent;
                     tok_in.inserted = 1'b1;
                  end
               end else if (sid_eq) begin
                  tok_in.mode = MODE_DONE;
                  tok_in.idx  = SLOT_IDX;
                  if (newer) begin
                     tok_in.status = ST_NEWER;
                     if (tok_i.func == FUNC_MERGE) begin
                        ent_in = tok_i.ent;
                     end
                  end else if (same) begin
                     tok_in.status = ST_EQUAL;
                  end else begin
                     tok_in.status = ST_OLDER;
                  end
               end else if (sid_lt) begin
                  if (tok_i.func == FUNC_COMPARE) begin
                     tok_in.mode   = MODE_DONE;
                     tok_in.status = ST_NEWID;
                     tok_in.idx    = SLOT_IDX;
                  end else if (ctl.full) begin
                     tok_in.mode   = MODE_DONE;
                     tok_in.status = ST_FULL;
                     tok_in.idx    = '0;
                  end else begin
                     // take the new entry, push the old one down the row
                     ent_in          = tok_i.ent;
                     tok_in.ent      = ent_ff;
                     tok_in.mode     = MODE_CARRY;
                     tok_in.status   = ST_NEWID;
                     tok_in.idx      = SLOT_IDX;
                     tok_in.inserted = 1'b1;
                  end
               end
            end
            MODE_CARRY: begin
               ent_in     = tok_i.ent;
               tok_in.ent = ent_ff;
               if (!occupied) begin
                  tok_in.mode = MODE_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_vld_ff <= 1'b0;
      end else if (ctl.advance) begin
         tok_vld_ff <= tok_vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         tok_ff <= tok_in;
         ent_ff <= ent_in;
      end
   end

   assign tok_vld_o = tok_vld_ff;
   assign tok_o     = tok_ff;

endmodule

`default_nettype wire

// File: sv/sorted_sid_stamp_table_unit.sv
// Vector clock table: per-server latest change stamp, kept sorted by server id.
// req_ channel: one stamp per transfer with its server id, a validity flag and
// the operation (merge into the table, or compare only).
// rsp_ channel: one result per request: status, slot index, occupied slot
// count after the request, and the quorum notify pulse.
// csr_ channel: writes notify_enable; always ready, write only while idle.
// The table is a row of MAX_SLOTS cells; a request token walks the row one
// cell per cycle while the row is not frozen, matching, updating or inserting,
// with later entries shifted along the row behind an insert.
// Path: a request is registered in the launch register, then in each cell of
// the row in turn, then in the result register. One request is in the row at
// a time, so a new request is taken in the cycle after its predecessor's
// result is loaded.
// Reset empties the table and clears notify_enable; no clearing pass.
// A stalled rsp_ holds its result; a token reaching the end of the row waits
// with the whole row frozen until the result register frees.
`default_nettype none

module sorted_sid_stamp_table_unit
   import ssst_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_func,
   input  wire logic                req_stamp_valid,
   input  wire logic [SID_W-1:0]    req_server_id,
   input  wire logic [DT_W-1:0]     req_date_time,
   input  wire logic [MICROS_W-1:0] req_micros,
   input  wire logic [CHG_W-1:0]    req_change_count,
   input  wire logic [MOD_W-1:0]    req_modifier,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [IDX_W-1:0]         rsp_slot_index,
   output logic [ECNT_W-1:0]        rsp_entry_count,
   output logic                     rsp_quorum_notify,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_notify_enable
);

   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);
   localparam logic [IDX_W-1:0] END_IDX = (MAX_SLOTS > 31) ? IDX_CAP : IDX_W'(MAX_SLOTS);

   token_type           chain_tok [MAX_SLOTS+1];
   logic                chain_vld [MAX_SLOTS+1];
   chain_ctl_type       ctl;

   token_type           launch_ff, launch_in;
   logic                launch_vld_ff;
   logic                busy_ff;
   logic                notify_en_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, status_in;
   logic [IDX_W-1:0]    rsp_idx_ff, idx_in;
   logic [ECNT_W-1:0]   rsp_cnt_ff;
   logic                rsp_notify_ff;
   logic [31:0]         count_wide;
   logic                req_xfer;
   logic                end_take;
   token_type           end_tok;

   assign req_ready = !busy_ff;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign end_tok  = chain_tok[MAX_SLOTS];
   assign end_take = chain_vld[MAX_SLOTS] && (!rsp_valid_ff || rsp_ready);

   assign ctl.advance = !(chain_vld[MAX_SLOTS] && rsp_valid_ff && !rsp_ready);
   assign ctl.full    = count_ff == CNT_MAX;

   always_comb begin
      launch_in.mode      = req_stamp_valid ? MODE_SEARCH : MODE_DONE;
      launch_in.func      = req_func;
      launch_in.status    = ST_INVALID;
      launch_in.idx       = '0;
      launch_in.inserted  = 1'b0;
      launch_in.ent.sid   = req_server_id;
      launch_in.ent.dt    = req_date_time;
      launch_in.ent.mc    = {req_micros, req_change_count};
      launch_in.ent.mod   = req_modifier;
   end

   assign chain_tok[0] = launch_ff;
   assign chain_vld[0] = launch_vld_ff;

   for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
      ssst_cell #(
         .CNT_W (CNT_W),
         .POS   (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .count     (count_ff),
         .tok_vld_i (chain_vld[g]),
         .tok_i     (chain_tok[g]),
         .tok_vld_o (chain_vld[g+1]),
         .tok_o     (chain_tok[g+1])
      );
   end

   // a token still searching at the end of the row is past every stored id
   always_comb begin
      status_in = end_tok.status;
      idx_in    = end_tok.idx;
      if (end_tok.mode == MODE_SEARCH) begin
         if (end_tok.func == FUNC_MERGE) begin
            status_in = ST_FULL;
            idx_in    = '0;
         end else begin
            status_in = ST_NEWID;
            idx_in    = END_IDX;
         end
      end
   end

   assign count_in   = (end_tok.mode != MODE_SEARCH && end_tok.inserted) ?
                       count_ff + CNT_W'(1) : count_ff;
   assign count_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_vld_ff <= 1'b0;
         busy_ff       <= 1'b0;
         notify_en_ff  <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            notify_en_ff <= csr_notify_enable;
         end
         if (req_xfer) begin
            launch_vld_ff <= 1'b1;
            busy_ff       <= 1'b1;
         end else if (ctl.advance) begin
            launch_vld_ff <= 1'b0;
         end
         if (end_take) begin
            busy_ff      <= 1'b0;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         launch_ff <= launch_in;
      end
      if (end_take) begin
         rsp_status_ff <= status_in;
         rsp_idx_ff    <= idx_in;
         rsp_cnt_ff    <= count_wide[ECNT_W-1:0];
         rsp_notify_ff <= (end_tok.mode != MODE_SEARCH) && end_tok.inserted && notify_en_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_index    = rsp_idx_ff;
   assign rsp_entry_count   = rsp_cnt_ff;
   assign rsp_quorum_notify = rsp_notify_ff;

endmodule

`default_nettype wire

// File: sv/ssst_chk.sv
`default_nettype none

module ssst_chk
   import ssst_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [IDX_W-1:0]    rsp_slot_index,
   input wire logic                rsp_quorum_notify
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot_index) && $stable(rsp_quorum_notify))
      else $error("stalled result changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_notify_newid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quorum_notify |-> rsp_status == ST_NEWID)
      else $error("notify without insert");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL)
      else $error("unknown status code");

   a_reject_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_INVALID || rsp_status == ST_FULL)
         |-> rsp_slot_index == '0)
      else $error("rejected request with nonzero slot index");

endmodule

bind sorted_sid_stamp_table_unit ssst_chk u_ssst_chk (.*);

`default_nettype wire
